FILE: rtl/core/rmrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rmrd_pkg;

	// coordinate widths that cover the whole allowed panel size range
	localparam int X_W = 6;
	localparam int Y_W = 8;

	localparam logic [2:0] REQ_PIXEL   = 3'd0;
	localparam logic [2:0] REQ_HLINE   = 3'd1;
	localparam logic [2:0] REQ_VLINE   = 3'd2;
	localparam logic [2:0] REQ_OUTLINE = 3'd3;
	localparam logic [2:0] REQ_FILL    = 3'd4;
	localparam logic [2:0] REQ_CLEAR   = 3'd5;
	localparam logic [2:0] REQ_READ    = 3'd6;

	typedef enum logic [1:0] {
		OP_SKIP,
		OP_FILL,
		OP_CLEAR,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t             op;
		logic            on;
		logic            last;
		logic [2:0]      kind;
		logic [8:0]      addr;
		logic [X_W-1:0]  x0;
		logic [X_W-1:0]  x1;
		logic [Y_W-1:0]  y0;
		logic [Y_W-1:0]  y1;
	} job_t;

	typedef struct packed {
		logic [7:0] data;
		logic [2:0] kind;
	} res_t;

	typedef enum logic [2:0] {
		BK_INIT,
		BK_IDLE,
		BK_RD,
		BK_WR,
		BK_CLR,
		BK_READ,
		BK_DONE
	} bstate_t;

endpackage

`default_nettype wire

FILE: rtl/core/rmrd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module rmrd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rd_data = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push_ok) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop_ok) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			case ({push_ok, pop_ok})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			slot_q[wptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/rmrd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rmrd_front #(
	parameter int PANEL_COLUMNS = 128,
	parameter int PANEL_ROWS    = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               hold,
	input  logic [2:0]         req_type,
	input  logic signed [11:0] start_x,
	input  logic signed [11:0] start_y,
	input  logic signed [11:0] end_or_width,
	input  logic signed [11:0] rect_height,
	input  logic               pixel_on,
	input  logic [8:0]         read_address,
	output logic               job_push,
	output rmrd_pkg::job_t     job,
	input  logic               job_full
);

	localparam logic signed [13:0] XMAX = 14'(PANEL_ROWS - 1);
	localparam logic signed [13:0] YMAX = 14'(PANEL_COLUMNS - 1);

	logic               busy_q;
	logic [1:0]         step_q;
	logic [2:0]         kind_q;
	logic signed [11:0] x_q;
	logic signed [11:0] y_q;
	logic signed [11:0] e_q;
	logic signed [11:0] h_q;
	logic               on_q;
	logic [8:0]         addr_q;

	logic signed [13:0] xs, ys, es, hs, xe, yh;
	logic signed [13:0] xa, xb, ya, yb;
	logic signed [13:0] xlo, xhi, ylo, yhi;
	logic               positive;
	logic               draw_kind;
	logic               empty_rect;
	logic               accept;

	assign accept = push && !full;
	assign full   = busy_q || hold;

	assign xs = {{2{x_q[11]}}, x_q};
	assign ys = {{2{y_q[11]}}, y_q};
	assign es = {{2{e_q[11]}}, e_q};
	assign hs = {{2{h_q[11]}}, h_q};
	assign xe = xs + es - 14'sd1;
	assign yh = ys + hs - 14'sd1;
	assign positive = (e_q > 12'sd0) && (h_q > 12'sd0);

	// pick the span or rectangle for this step
	always_comb begin
		xa = xs;
		xb = xs;
		ya = ys;
		yb = ys;
		draw_kind = 1'b1;
		case (kind_q)
			rmrd_pkg::REQ_PIXEL: begin
				draw_kind = 1'b1;
			end
			rmrd_pkg::REQ_HLINE: begin
				if (xs > es) begin
					xa = es;
					xb = xs;
				end else begin
					xb = es;
				end
			end
			rmrd_pkg::REQ_VLINE: begin
				if (ys > es) begin
					ya = es;
					yb = ys;
				end else begin
					yb = es;
				end
			end
			rmrd_pkg::REQ_OUTLINE: begin
				draw_kind = positive;
				case (step_q)
					2'd0: begin
						xb = xe;
					end
					2'd1: begin
						xb = xe;
						ya = yh;
						yb = yh;
					end
					2'd2: begin
						yb = yh;
					end
					default: begin
						xa = xe;
						xb = xe;
						yb = yh;
					end
				endcase
			end
			rmrd_pkg::REQ_FILL: begin
				draw_kind = positive;
				xb = xe;
				yb = yh;
			end
			default: begin
				draw_kind = 1'b0;
			end
		endcase
	end

	// clip against the logical plane
	always_comb begin
		empty_rect = (xa > xb) || (ya > yb) || (xb < 14'sd0) || (xa > XMAX) ||
			(yb < 14'sd0) || (ya > YMAX);
		xlo = (xa < 14'sd0) ? 14'sd0 : xa;
		xhi = (xb > XMAX) ? XMAX : xb;
		ylo = (ya < 14'sd0) ? 14'sd0 : ya;
		yhi = (yb > YMAX) ? YMAX : yb;
	end

	always_comb begin
		if (kind_q == rmrd_pkg::REQ_CLEAR) begin
			job.op = rmrd_pkg::OP_CLEAR;
		end else if (kind_q == rmrd_pkg::REQ_READ) begin
			job.op = rmrd_pkg::OP_READ;
		end else if (draw_kind && !empty_rect) begin
			job.op = rmrd_pkg::OP_FILL;
		end else begin
			job.op = rmrd_pkg::OP_SKIP;
		end
		job.on   = on_q;
		job.last = (kind_q != rmrd_pkg::REQ_OUTLINE) || (step_q == 2'd3);
		job.kind = kind_q;
		job.addr = addr_q;
		job.x0   = xlo[rmrd_pkg::X_W-1:0];
		job.x1   = xhi[rmrd_pkg::X_W-1:0];
		job.y0   = ylo[rmrd_pkg::Y_W-1:0];
		job.y1   = yhi[rmrd_pkg::Y_W-1:0];
	end

	assign job_push = busy_q && !job_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
		end else if (accept) begin
			busy_q <= 1'b1;
			step_q <= 2'd0;
		end else if (job_push) begin
			if (job.last) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= req_type;
			x_q    <= start_x;
			y_q    <= start_y;
			e_q    <= end_or_width;
			h_q    <= rect_height;
			on_q   <= pixel_on;
			addr_q <= read_address;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/rmrd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rmrd_back #(
	parameter int PANEL_COLUMNS = 128,
	parameter int PANEL_ROWS    = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_data,
	input  rmrd_pkg::job_t job,
	input  logic           job_empty,
	output logic           job_pop,
	input  logic           res_full,
	output logic           res_push,
	output rmrd_pkg::res_t res,
	output logic           init_busy
);

	localparam int STORE_BYTES = PANEL_COLUMNS * PANEL_ROWS / 8;
	localparam int AW          = $clog2(STORE_BYTES);
	localparam int XW          = rmrd_pkg::X_W;
	localparam int YW          = rmrd_pkg::Y_W;
	localparam int TW          = XW - 3;

	rmrd_pkg::bstate_t state_q, state_d;
	rmrd_pkg::job_t    job_q;
	logic [TW-1:0]     tile_q;
	logic [YW-1:0]     ycur_q;
	logic [AW-1:0]     clr_q;
	logic              msb_first_q;
	logic [7:0]        rd_q;
	logic [7:0]        mem_q [STORE_BYTES];

	logic [AW-1:0]     byte_addr;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;
	logic [7:0]        wdata;
	logic              we;
	logic              re;
	logic [7:0]        mask;
	logic [7:0]        new_byte;
	logic [XW-1:0]     row_v;
	logic              in_range;
	logic              clr_last;
	logic              span_last;

	assign byte_addr = AW'(tile_q) * AW'(PANEL_COLUMNS) + AW'(PANEL_COLUMNS - 1) - AW'(ycur_q);
	assign clr_last  = (clr_q == AW'(STORE_BYTES - 1));
	assign span_last = (ycur_q == job_q.y1) && (tile_q == job_q.x1[XW-1:3]);
	assign in_range  = (32'(job_q.addr) < 32'(STORE_BYTES));
	assign init_busy = (state_q == rmrd_pkg::BK_INIT);

	// bits of the current tile that fall inside the span
	always_comb begin
		mask  = 8'd0;
		row_v = '0;
		for (int p = 0; p < 8; p++) begin
			row_v = {tile_q, p[2:0]};
			mask[msb_first_q ? 3'(7 - p) : 3'(p)] = (row_v >= job_q.x0) && (row_v <= job_q.x1);
		end
	end

	assign new_byte = job_q.on ? (rd_q & ~mask) : (rd_q | mask);

	assign res.data = ((job_q.op == rmrd_pkg::OP_READ) && in_range) ? rd_q : 8'd0;
	assign res.kind = job_q.kind;

	always_comb begin
		state_d  = state_q;
		job_pop  = 1'b0;
		res_push = 1'b0;
		we       = 1'b0;
		re       = 1'b0;
		waddr    = byte_addr;
		wdata    = new_byte;
		raddr    = byte_addr;
		case (state_q)
			rmrd_pkg::BK_INIT: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = 8'hFF;
				if (clr_last) begin
					state_d = rmrd_pkg::BK_IDLE;
				end
			end
			rmrd_pkg::BK_IDLE: begin
				if (!job_empty) begin
					job_pop = 1'b1;
					case (job.op)
						rmrd_pkg::OP_FILL:  state_d = rmrd_pkg::BK_RD;
						rmrd_pkg::OP_CLEAR: state_d = rmrd_pkg::BK_CLR;
						rmrd_pkg::OP_READ:  state_d = rmrd_pkg::BK_READ;
						default:            state_d = rmrd_pkg::BK_DONE;
					endcase
				end
			end
			rmrd_pkg::BK_RD: begin
				re      = 1'b1;
				state_d = rmrd_pkg::BK_WR;
			end
			rmrd_pkg::BK_WR: begin
				we      = 1'b1;
				state_d = span_last ? rmrd_pkg::BK_DONE : rmrd_pkg::BK_RD;
			end
			rmrd_pkg::BK_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = 8'hFF;
				if (clr_last) begin
					state_d = rmrd_pkg::BK_DONE;
				end
			end
			rmrd_pkg::BK_READ: begin
				re      = 1'b1;
				raddr   = AW'(job_q.addr);
				state_d = rmrd_pkg::BK_DONE;
			end
			rmrd_pkg::BK_DONE: begin
				if (!job_q.last) begin
					state_d = rmrd_pkg::BK_IDLE;
				end else if (!res_full) begin
					res_push = 1'b1;
					state_d  = rmrd_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = rmrd_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rmrd_pkg::BK_INIT;
			clr_q       <= '0;
			tile_q      <= '0;
			ycur_q      <= '0;
			msb_first_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				msb_first_q <= cfg_data;
			end
			if (job_pop) begin
				tile_q <= job.x0[XW-1:3];
				ycur_q <= job.y0;
				clr_q  <= '0;
			end else if (state_q == rmrd_pkg::BK_WR) begin
				if (ycur_q == job_q.y1) begin
					ycur_q <= job_q.y0;
					tile_q <= tile_q + TW'(1);
				end else begin
					ycur_q <= ycur_q + YW'(1);
				end
			end else if ((state_q == rmrd_pkg::BK_INIT) || (state_q == rmrd_pkg::BK_CLR)) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/rotated_mono_raster_draw_top.sv
// lines and filled rectangles take one read-modify-write per framebuffer byte touched;
//   outlines run four spans, and clear writes every byte once
// the back end takes one job at a time through the frame store, and the byte walk sets the rate
// reset: after arst_n releases, a fill pass writes 0xFF to every byte
//   with full held high; config register resets to lsb-first
`timescale 1ns / 1ps
`default_nettype none

module rotated_mono_raster_draw_top #(
	parameter int PANEL_COLUMNS = 128,
	parameter int PANEL_ROWS    = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [2:0]         req_type,
	input  logic signed [11:0] start_x,
	input  logic signed [11:0] start_y,
	input  logic signed [11:0] end_or_width,
	input  logic signed [11:0] rect_height,
	input  logic               pixel_on,
	input  logic [8:0]         read_address,
	output logic               empty,
	input  logic               pop,
	output logic [7:0]         read_data,
	output logic [2:0]         done_kind,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data
);

	localparam int JOB_W = $bits(rmrd_pkg::job_t);
	localparam int RES_W = $bits(rmrd_pkg::res_t);

	rmrd_pkg::job_t front_job;
	rmrd_pkg::job_t back_job;
	rmrd_pkg::res_t back_res;
	rmrd_pkg::res_t out_res;
	logic           job_push;
	logic           job_full;
	logic           job_pop;
	logic           job_empty;
	logic           res_push;
	logic           res_full;
	logic           init_busy;

	assign cfg_ready = 1'b1;

	rmrd_front #(
		.PANEL_COLUMNS(PANEL_COLUMNS),
		.PANEL_ROWS   (PANEL_ROWS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.hold        (init_busy),
		.req_type    (req_type),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_or_width(end_or_width),
		.rect_height (rect_height),
		.pixel_on    (pixel_on),
		.read_address(read_address),
		.job_push    (job_push),
		.job         (front_job),
		.job_full    (job_full)
	);

	rmrd_fifo #(
		.WIDTH(JOB_W),
		.DEPTH(2)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wr_data(front_job),
		.full   (job_full),
		.pop    (job_pop),
		.rd_data(back_job),
		.empty  (job_empty)
	);

	rmrd_back #(
		.PANEL_COLUMNS(PANEL_COLUMNS),
		.PANEL_ROWS   (PANEL_ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.job      (back_job),
		.job_empty(job_empty),
		.job_pop  (job_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (back_res),
		.init_busy(init_busy)
	);

	rmrd_fifo #(
		.WIDTH(RES_W),
		.DEPTH(2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wr_data(back_res),
		.full   (res_full),
		.pop    (pop),
		.rd_data(out_res),
		.empty  (empty)
	);

	assign read_data = out_res.data;
	assign done_kind = out_res.kind;

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");

	a_quiet_during_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> (empty && job_empty))
		else $error("item in flight during frame store fill");

	a_zero_data_for_draw: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (done_kind != rmrd_pkg::REQ_READ)) |-> (read_data == 8'd0))
		else $error("nonzero read data on a non-read item");

endmodule

`default_nettype wire

FILE: tb/tb_rotated_mono_raster_draw_top.sv
`timescale 1ns / 1ps

module tb_rotated_mono_raster_draw_top;

	localparam int COLS = 128;
	localparam int ROWS = 32;
	localparam int FB_BYTES = COLS * ROWS / 8;
	localparam logic [2:0] REQ_NONE = 3'd7;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [2:0]         kind;
		logic signed [11:0] x;
		logic signed [11:0] y;
		logic signed [11:0] e;
		logic signed [11:0] h;
		logic               on;
		logic [8:0]         addr;
	} cmd_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [2:0]         req_type;
	logic signed [11:0] start_x;
	logic signed [11:0] start_y;
	logic signed [11:0] end_or_width;
	logic signed [11:0] rect_height;
	logic               pixel_on;
	logic [8:0]         read_address;
	logic               empty;
	logic               pop = 1'b0;
	logic [7:0]         read_data;
	logic [2:0]         done_kind;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_data;

	logic [7:0]     shadow_fb [FB_BYTES];
	bit             msb_mode;
	rmrd_pkg::res_t pending_results[$];
	rmrd_pkg::res_t oldest;
	bit             steady = 1'b0;
	int             n_sent, n_reads, n_checked, n_mismatch, n_cfg, idle_cycles;

	rotated_mono_raster_draw_top #(
		.PANEL_COLUMNS(COLS),
		.PANEL_ROWS(ROWS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req_type(req_type),
		.start_x(start_x),
		.start_y(start_y),
		.end_or_width(end_or_width),
		.rect_height(rect_height),
		.pixel_on(pixel_on),
		.read_address(read_address),
		.empty(empty),
		.pop(pop),
		.read_data(read_data),
		.done_kind(done_kind),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// framebuffer predictor
	function automatic void put_dot(int x, int y, bit on);
		int idx;
		int b;
		if (x < 0 || x >= ROWS || y < 0 || y >= COLS)
			return;
		idx = (x / 8) * COLS + (COLS - 1 - y);
		b = msb_mode ? 7 - (x % 8) : x % 8;
		shadow_fb[idx][b] = ~on;
	endfunction

	function automatic void draw_row(int x0, int x1, int y, bit on);
		int t;
		if (x0 > x1) begin
			t = x0;
			x0 = x1;
			x1 = t;
		end
		if (y < 0 || y >= COLS)
			return;
		if (x0 < 0)
			x0 = 0;
		if (x1 > ROWS - 1)
			x1 = ROWS - 1;
		for (t = x0; t <= x1; t++)
			put_dot(t, y, on);
	endfunction

	function automatic void draw_col(int x, int y0, int y1, bit on);
		int t;
		if (y0 > y1) begin
			t = y0;
			y0 = y1;
			y1 = t;
		end
		if (x < 0 || x >= ROWS)
			return;
		if (y0 < 0)
			y0 = 0;
		if (y1 > COLS - 1)
			y1 = COLS - 1;
		for (t = y0; t <= y1; t++)
			put_dot(x, t, on);
	endfunction

	function automatic rmrd_pkg::res_t predict_draw(cmd_t c);
		rmrd_pkg::res_t r;
		int x, y, e, h, lo, hi, row;
		x = c.x;
		y = c.y;
		e = c.e;
		h = c.h;
		r.data = 8'h00;
		r.kind = c.kind;
		case (c.kind)
			rmrd_pkg::REQ_PIXEL: put_dot(x, y, c.on);
			rmrd_pkg::REQ_HLINE: draw_row(x, e, y, c.on);
			rmrd_pkg::REQ_VLINE: draw_col(x, y, e, c.on);
			rmrd_pkg::REQ_OUTLINE: begin
				if (e > 0 && h > 0) begin
					draw_row(x, x + e - 1, y, c.on);
					draw_row(x, x + e - 1, y + h - 1, c.on);
					draw_col(x, y, y + h - 1, c.on);
					draw_col(x + e - 1, y, y + h - 1, c.on);
				end
			end
			rmrd_pkg::REQ_FILL: begin
				if (e > 0 && h > 0) begin
					lo = y < 0 ? 0 : y;
					hi = y + h - 1;
					if (hi > COLS - 1)
						hi = COLS - 1;
					for (row = lo; row <= hi; row++)
						draw_row(x, x + e - 1, row, c.on);
				end
			end
			rmrd_pkg::REQ_CLEAR: begin
				foreach (shadow_fb[i])
					shadow_fb[i] = 8'hFF;
			end
			rmrd_pkg::REQ_READ: r.data = shadow_fb[c.addr];
			default: ;
		endcase
		return r;
	endfunction

	function automatic cmd_t mk(logic [2:0] k, int x, int y, int e, int h, bit on, int addr);
		cmd_t c;
		c.kind = k;
		c.x = x[11:0];
		c.y = y[11:0];
		c.e = e[11:0];
		c.h = h[11:0];
		c.on = on;
		c.addr = addr[8:0];
		return c;
	endfunction

	// mostly near the plane, now and then anywhere in the 12-bit range
	function automatic logic [11:0] coord(int lo, int hi, int wide_pct);
		int v;
		if ($urandom_range(99) < wide_pct)
			return 12'($urandom);
		v = lo + int'($urandom_range(hi - lo));
		return v[11:0];
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int pick, px, py, a;
		pick = $urandom_range(99);
		if (pick < 14)
			c.kind = rmrd_pkg::REQ_PIXEL;
		else if (pick < 26)
			c.kind = rmrd_pkg::REQ_HLINE;
		else if (pick < 38)
			c.kind = rmrd_pkg::REQ_VLINE;
		else if (pick < 48)
			c.kind = rmrd_pkg::REQ_OUTLINE;
		else if (pick < 58)
			c.kind = rmrd_pkg::REQ_FILL;
		else if (pick < 61)
			c.kind = rmrd_pkg::REQ_CLEAR;
		else if (pick < 97)
			c.kind = rmrd_pkg::REQ_READ;
		else
			c.kind = REQ_NONE;
		c.x = coord(-6, ROWS + 5, 12);
		c.y = coord(-6, COLS + 5, 12);
		c.h = 12'($urandom);
		case (c.kind)
			rmrd_pkg::REQ_HLINE: c.e = coord(-6, ROWS + 5, 12);
			rmrd_pkg::REQ_VLINE: c.e = coord(-6, COLS + 5, 12);
			rmrd_pkg::REQ_OUTLINE, rmrd_pkg::REQ_FILL: begin
				c.e = coord(-2, 20, 8);
				c.h = coord(-2, 40, 8);
			end
			default: c.e = 12'($urandom);
		endcase
		c.on = 1'($urandom_range(1));
		px = $urandom_range(ROWS - 1);
		py = $urandom_range(COLS - 1);
		a = (px / 8) * COLS + (COLS - 1 - py);
		c.addr = $urandom_range(1) ? a[8:0] : 9'($urandom_range(FB_BYTES - 1));
		return c;
	endfunction

	task automatic send_cmd(cmd_t c);
		@(negedge clk);
		if (!steady && $urandom_range(99) < 38) begin
			push <= 1'b0;
			repeat ($urandom_range(6, 1)) @(negedge clk);
		end
		req_type <= c.kind;
		start_x <= c.x;
		start_y <= c.y;
		end_or_width <= c.e;
		rect_height <= c.h;
		pixel_on <= c.on;
		read_address <= c.addr;
		push <= 1'b1;
		do @(posedge clk); while (full);
		pending_results.push_back(predict_draw(c));
		n_sent++;
		if (c.kind == rmrd_pkg::REQ_READ)
			n_reads++;
	endtask

	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_mode(bit v);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		msb_mode = v;
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic note_bad(string what, int want, int got);
		n_mismatch++;
		if (n_mismatch <= 10)
			$display("bad %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
	endtask

	// result side
	always @(negedge clk)
		pop <= steady ? 1'b1 : ($urandom_range(99) >= 38);

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				note_bad("unexpected item, kind", -1, done_kind);
			end else begin
				oldest = pending_results.pop_front();
				n_checked++;
				if (read_data !== oldest.data)
					note_bad("read_data", oldest.data, read_data);
				if (done_kind !== oldest.kind)
					note_bad("done_kind", oldest.kind, done_kind);
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("no progress for %0d cycles, %0d items pending", STALL_LIMIT,
				pending_results.size());
			$display("rotated_mono_raster_draw_top: mismatch");
			$finish;
		end
	end

	task automatic test_pixels();
		send_cmd(mk(rmrd_pkg::REQ_PIXEL, 0, 0, 0, 0, 1, 0));
		send_cmd(mk(rmrd_pkg::REQ_PIXEL, ROWS - 1, COLS - 1, 0, 0, 1, 0));
		send_cmd(mk(rmrd_pkg::REQ_PIXEL, -1, 5, 0, 0, 1, 0));
		send_cmd(mk(rmrd_pkg::REQ_PIXEL, ROWS, 5, 0, 0, 1, 0));
		send_cmd(mk(rmrd_pkg::REQ_PIXEL, 0, COLS, 0, 0, 1, 0));
		send_cmd(mk(rmrd_pkg::REQ_PIXEL, -2048, 2047, -2048, 2047, 1, 511));
		send_cmd(mk(rmrd_pkg::REQ_READ, 0, 0, 0, 0, 0, COLS - 1));
		send_cmd(mk(rmrd_pkg::REQ_READ, 0, 0, 0, 0, 0, 3 * COLS));
	endtask

	task automatic test_lines();
		send_cmd(mk(rmrd_pkg::REQ_HLINE, -5, 10, 40, 0, 1, 0));
		send_cmd(mk(rmrd_pkg::REQ_HLINE, 20, 64, 3, 0, 1, 0));
		send_cmd(mk(rmrd_pkg::REQ_VLINE, 7, 130, -3, 0, 1, 0));
		send_cmd(mk(rmrd_pkg::REQ_VLINE, -1, 0, 127, 0, 1, 0));
		send_cmd(mk(rmrd_pkg::REQ_HLINE, 2047, 10, -2048, 0, 0, 0));
		send_cmd(mk(rmrd_pkg::REQ_READ, 0, 0, 0, 0, 0, COLS - 1 - 10));
	endtask

	task automatic test_rects();
		send_cmd(mk(rmrd_pkg::REQ_OUTLINE, 2, 2, 10, 20, 1, 0));
		send_cmd(mk(rmrd_pkg::REQ_FILL, -3, 120, 12, 20, 1, 0));
		send_cmd(mk(rmrd_pkg::REQ_FILL, 5, 5, 0, 10, 1, 0));
		send_cmd(mk(rmrd_pkg::REQ_OUTLINE, 5, 5, 10, -1, 1, 0));
		send_cmd(mk(rmrd_pkg::REQ_OUTLINE, -2048, -2048, 2047, 2047, 0, 0));
		send_cmd(mk(rmrd_pkg::REQ_READ, 0, 0, 0, 0, 0, COLS - 1 - 2));
	endtask

	task automatic test_clear_read();
		send_cmd(mk(rmrd_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0));
		send_cmd(mk(rmrd_pkg::REQ_READ, 0, 0, 0, 0, 1, 0));
		send_cmd(mk(REQ_NONE, 2047, -2048, 2047, -2048, 1, 511));
		send_cmd(mk(rmrd_pkg::REQ_READ, 0, 0, 0, 0, 1, FB_BYTES - 1));
	endtask

	task automatic test_bit_order();
		write_mode(1'b1);
		send_cmd(mk(rmrd_pkg::REQ_PIXEL, 3, 0, 0, 0, 1, 0));
		send_cmd(mk(rmrd_pkg::REQ_READ, 0, 0, 0, 0, 0, COLS - 1));
		write_mode(1'b0);
	endtask

	task automatic test_random(int count, bit mode, bit no_idle, bit pause_midway);
		write_mode(mode);
		steady = no_idle;
		for (int i = 0; i < count; i++) begin
			if (pause_midway && i == count / 2)
				drain();
			send_cmd(rand_cmd());
		end
		drain();
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		req_type = rmrd_pkg::REQ_PIXEL;
		start_x = '0;
		start_y = '0;
		end_or_width = '0;
		rect_height = '0;
		pixel_on = 1'b0;
		read_address = '0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		idle_cycles = 0;
		msb_mode = 1'b0;
		foreach (shadow_fb[i])
			shadow_fb[i] = 8'hFF;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_pixels();
		test_lines();
		test_rects();
		test_clear_read();
		test_bit_order();
		test_random(185, 1'b1, 1'b0, 1'b1);
		test_random(185, 1'b0, 1'b1, 1'b0);
		test_random(185, 1'b1, 1'b0, 1'b0);
		test_random(185, 1'b0, 1'b0, 1'b1);

		drain();
		repeat (16) @(posedge clk);
		$display("sent %0d draw/clear/read items (%0d byte reads), checked %0d results",
			n_sent, n_reads, n_checked);
		$display("bit order switched %0d times; %0d bad fields, %0d results outstanding",
			n_cfg, n_mismatch, pending_results.size());
		if (n_mismatch == 0 && pending_results.size() == 0)
			$display("rotated_mono_raster_draw_top: match");
		else
			$display("rotated_mono_raster_draw_top: mismatch");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/rmrd_pkg.sv
rtl/core/rmrd_fifo.sv
rtl/core/rmrd_front.sv
rtl/core/rmrd_back.sv
rtl/core/rotated_mono_raster_draw_top.sv
tb/tb_rotated_mono_raster_draw_top.sv
